// ===== rtl/core/sbrp_pkg.sv =====
// shared types and constants for the sprite bitplane row packer
package sbrp_pkg;

  localparam int SPRITE_COLUMNS   = 16;
  localparam int MAX_SOURCE_WIDTH = 256;
  localparam int WIDTH_W          = 9;
  localparam int HEIGHT_W         = 8;
  localparam int COL_W            = 8;
  localparam int ROW_W            = 8;
  localparam int WORD_W           = 16;
  localparam int CFG_IDX_W        = 1;
  localparam int CFG_DATA_W       = 9;
  localparam int SRC_W            = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 1'd1;

  localparam logic [WIDTH_W-1:0]  RST_SOURCE_WIDTH  = 9'd16;
  localparam logic [HEIGHT_W-1:0] RST_SOURCE_HEIGHT = 8'd16;

  // back end word groups
  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_PLANES = 2'd1;
  localparam logic [1:0] PH_TERM   = 2'd2;

  typedef struct packed {
    logic       pixel_visible;
    logic [1:0] pixel_code;
  } in_word_t;

  typedef struct packed {
    logic [WORD_W-1:0] output_word;
    logic              last_word;
  } out_word_t;

  // one queued job: which word groups to send and the finished plane words
  typedef struct packed {
    logic              header;
    logic              row_end;
    logic              frame_end;
    logic [WORD_W-1:0] plane_low;
    logic [WORD_W-1:0] plane_high;
  } job_t;

endpackage

// ===== rtl/core/sbrp_front.sv =====
// front end: config registers, resampling, plane build, job generation
module sbrp_front import sbrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  q_full,
  output logic                  q_push,
  output job_t                  q_job
);

  logic [WIDTH_W-1:0]  width_r;
  logic [HEIGHT_W-1:0] height_r;
  logic [COL_W-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0]    row_r, row_nxt;
  logic [WORD_W-1:0]   low_r, low_nxt, high_r, high_nxt;
  logic                hdr_sent_r, hdr_sent_nxt;

  logic [WIDTH_W-1:0]  w_eff;
  logic [HEIGHT_W-1:0] h_eff;
  logic [WORD_W-1:0]   mask, low_new, high_new;
  logic                row_end, frame_end, accept;

  always_comb begin
    if (width_r == '0) begin
      w_eff = WIDTH_W'(1);
    end else if (width_r > WIDTH_W'(MAX_SOURCE_WIDTH)) begin
      w_eff = WIDTH_W'(MAX_SOURCE_WIDTH);
    end else begin
      w_eff = width_r;
    end
    h_eff = (height_r == '0) ? HEIGHT_W'(1) : height_r;
  end

  // nearest neighbour column map, column 0 at the msb
  always_comb begin
    logic [SRC_W-1:0] src_full;
    mask = '0;
    for (int x = 0; x < SPRITE_COLUMNS; x++) begin
      src_full = SRC_W'(x) * SRC_W'(w_eff) + SRC_W'(SPRITE_COLUMNS / 2);
      mask[SPRITE_COLUMNS-1-x] = (src_full[COL_W+3:4] == col_r);
    end
    if (!(in_data.pixel_visible && ({1'b0, col_r} < w_eff))) begin
      mask = '0;
    end
  end

  assign low_new   = low_r  | (mask & {WORD_W{in_data.pixel_code[0]}});
  assign high_new  = high_r | (mask & {WORD_W{in_data.pixel_code[1]}});
  assign row_end   = ({1'b0, col_r} >= (w_eff - WIDTH_W'(1)));
  assign frame_end = row_end && (({1'b0, row_r} + 9'd1) >= {1'b0, h_eff});

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && (!hdr_sent_r || row_end);

  always_comb begin
    q_job.header     = !hdr_sent_r;
    q_job.row_end    = row_end;
    q_job.frame_end  = frame_end;
    q_job.plane_low  = low_new;
    q_job.plane_high = high_new;
  end

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    low_nxt      = low_r;
    high_nxt     = high_r;
    hdr_sent_nxt = hdr_sent_r;
    if (accept) begin
      hdr_sent_nxt = !frame_end;
      if (row_end) begin
        col_nxt  = '0;
        low_nxt  = '0;
        high_nxt = '0;
        row_nxt  = frame_end ? '0 : row_r + ROW_W'(1);
      end else begin
        col_nxt  = col_r + COL_W'(1);
        low_nxt  = low_new;
        high_nxt = high_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= RST_SOURCE_WIDTH;
      height_r   <= RST_SOURCE_HEIGHT;
      col_r      <= '0;
      row_r      <= '0;
      low_r      <= '0;
      high_r     <= '0;
      hdr_sent_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SOURCE_WIDTH:  width_r  <= cfg_data;
          CFG_SOURCE_HEIGHT: height_r <= cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      low_r      <= low_nxt;
      high_r     <= high_nxt;
      hdr_sent_r <= hdr_sent_nxt;
    end
  end

endmodule

// ===== rtl/core/sbrp_queue.sv =====
// two-entry job queue between front and back end
module sbrp_queue import sbrp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t       mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign full       = (count_r == 2'd2);
  assign head_valid = (count_r != 2'd0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

// ===== rtl/core/sbrp_back.sv =====
// back end: expands queued jobs into output words
module sbrp_back import sbrp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  job_t      head_job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic [1:0] phase_r, phase_nxt, eff_phase;
  logic       half_r, half_nxt;
  logic       out_valid_r;
  out_word_t  out_data_r, word;
  logic       advance, done;

  // first group still due at or after phase_r
  always_comb begin
    if (phase_r == PH_HEADER && head_job.header) begin
      eff_phase = PH_HEADER;
    end else if (phase_r != PH_TERM && head_job.row_end) begin
      eff_phase = PH_PLANES;
    end else begin
      eff_phase = PH_TERM;
    end
  end

  always_comb begin
    word.last_word = 1'b0;
    case (eff_phase)
      PH_PLANES: word.output_word = half_r ? head_job.plane_high : head_job.plane_low;
      PH_TERM: begin
        word.output_word = '0;
        word.last_word   = half_r;
      end
      default:   word.output_word = '0;
    endcase
  end

  always_comb begin
    case (eff_phase)
      PH_HEADER: done = half_r && !head_job.row_end;
      PH_PLANES: done = half_r && !head_job.frame_end;
      default:   done = half_r;
    endcase
  end

  assign advance = head_valid && (!out_valid_r || out_ready);
  assign pop     = advance && done;

  always_comb begin
    phase_nxt = phase_r;
    half_nxt  = half_r;
    if (advance) begin
      half_nxt = !half_r;
      if (half_r) begin
        phase_nxt = done ? PH_HEADER : eff_phase + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      half_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== rtl/core/sprite_bitplane_row_packer.sv =====
// top level of the sprite bitplane row packer
//
//  channel | ports                         | word
//  --------+-------------------------------+-----------------------------------
//  pixel   | in_valid in_ready in_data     | visible flag, 2-bit color code
//  sprite  | out_valid out_ready out_data  | 16-bit data word, last flag
//  config  | cfg_we cfg_index cfg_data     | source width (0), height (1)
//
// one pixel is taken per clock; the front end builds the plane words and
// queues a job only at a frame start or row end, so the pixel rate is set
// by the two-entry job queue and the back end's one word per clock
// a row end job makes two back end words, a frame end four, a header two
// reset (rst_n, synchronous) clears counters, planes, queue and output
// valid flag and loads width 16 and height 16
// in_ready drops only while the job queue is full; out_ready stalls only
// the back end, the front keeps taking pixels until the queue fills
module sprite_bitplane_row_packer import sbrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data
);

  // front to queue
  logic q_full, q_push;
  job_t q_job;
  // queue to back
  logic q_head_valid, q_pop;
  job_t q_head_job;

  // resample, plane build, row and frame counting
  sbrp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (q_job)
  );

  // decouples pixel intake from word output
  sbrp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  // header, plane and terminator word sequencing
  sbrp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== test/sprite_row_check.sv =====
// checker for the sprite bitplane row packer: predicts sprite words and compares them
`timescale 1ns / 100ps

module sprite_row_check import sbrp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_word_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_word_t             out_data,
  output int                    fail_count,
  output int                    pending,
  output int                    words_checked,
  output int                    frames_closed
);

  // own copy of the registers and the packing state
  logic [WIDTH_W-1:0]  width_setting;
  logic [HEIGHT_W-1:0] height_setting;
  int                  col_pos;
  int                  rows_done;
  logic [WORD_W-1:0]   plane0_acc;
  logic [WORD_W-1:0]   plane1_acc;
  logic                header_out;

  out_word_t sprite_words_q[$];

  function automatic void queue_word(logic [WORD_W-1:0] data, logic last);
    out_word_t w;
    w.output_word = data;
    w.last_word   = last;
    sprite_words_q.push_back(w);
  endfunction

  function automatic void predict_sprite_words(in_word_t px);
    int w;
    int h;
    int src;
    int x;
    // out of range settings saturate
    if (width_setting == '0) w = 1;
    else if (width_setting > MAX_SOURCE_WIDTH) w = MAX_SOURCE_WIDTH;
    else w = int'(width_setting);
    h = (height_setting == '0) ? 1 : int'(height_setting);

    if (!header_out) begin
      queue_word('0, 1'b0);
      queue_word('0, 1'b0);
      header_out = 1'b1;
    end

    // nearest neighbour: column x reads source column (x*w+8)/16
    if (px.pixel_visible && col_pos < w) begin
      for (x = 0; x < SPRITE_COLUMNS; x++) begin
        src = (x * w + SPRITE_COLUMNS / 2) / SPRITE_COLUMNS;
        if (src < w && src == col_pos) begin
          if (px.pixel_code[0]) plane0_acc[WORD_W-1-x] = 1'b1;
          if (px.pixel_code[1]) plane1_acc[WORD_W-1-x] = 1'b1;
        end
      end
    end

    if (col_pos >= w - 1) begin
      queue_word(plane0_acc, 1'b0);
      queue_word(plane1_acc, 1'b0);
      plane0_acc = '0;
      plane1_acc = '0;
      col_pos    = 0;
      if (rows_done + 1 >= h) begin
        queue_word('0, 1'b0);
        queue_word('0, 1'b1);
        rows_done  = 0;
        header_out = 1'b0;
      end else begin
        rows_done = rows_done + 1;
      end
    end else begin
      col_pos = col_pos + 1;
    end
  endfunction

  always @(posedge clk) begin
    out_word_t want;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      width_setting  = RST_SOURCE_WIDTH;
      height_setting = RST_SOURCE_HEIGHT;
      col_pos        = 0;
      rows_done      = 0;
      plane0_acc     = '0;
      plane1_acc     = '0;
      header_out     = 1'b0;
      sprite_words_q.delete();
      fail_count    <= 0;
      words_checked <= 0;
      frames_closed <= 0;
      pending       <= 0;
    end else begin
      // compare first so a word can never match an expectation made this edge
      if (out_valid && out_ready) begin
        if (sprite_words_q.size() == 0) begin
          $error("unexpected sprite word %h last %b", out_data.output_word, out_data.last_word);
          errs++;
        end else begin
          want = sprite_words_q.pop_front();
          if (out_data.output_word !== want.output_word) begin
            $error("output_word mismatch: expected %h, actual %h",
                   want.output_word, out_data.output_word);
            errs++;
          end
          if (out_data.last_word !== want.last_word) begin
            $error("last_word mismatch: expected %b, actual %b",
                   want.last_word, out_data.last_word);
            errs++;
          end
          words_checked <= words_checked + 1;
          if (want.last_word) frames_closed <= frames_closed + 1;
        end
      end
      fail_count <= fail_count + errs;
      if (cfg_we) begin
        if (cfg_index == CFG_SOURCE_WIDTH) width_setting = cfg_data[WIDTH_W-1:0];
        else if (cfg_index == CFG_SOURCE_HEIGHT) height_setting = cfg_data[HEIGHT_W-1:0];
      end
      if (in_valid && in_ready) predict_sprite_words(in_data);
      pending <= sprite_words_q.size();
    end
  end

endmodule

// ===== test/tb.sv =====
// testbench top for the sprite bitplane row packer: stimulus, idling and verdict
`timescale 1ns / 100ps

module tb;
  import sbrp_pkg::*;

  localparam int PIXEL_TARGET   = 410;   // stimulus stops near this many pixel words
  localparam int SETTLE_CYCLES  = 8;     // back end may still be busy after the last word
  localparam int DRAIN_CYCLES   = 16;
  localparam int STALL_CYCLES   = 150;   // the one long receiver hold-off
  localparam int WATCHDOG_LIMIT = 3000;  // cycles with no word moving on either side

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  in_word_t              in_data;
  logic                  out_valid;
  logic                  out_ready;
  out_word_t             out_data;

  int fail_count;
  int pending;
  int words_checked;
  int frames_closed;

  int pixels_sent;
  int settings_used;
  int idle_cycles;
  bit burst_mode;     // sender offers back to back
  bit stall_req;      // asks the receiver for its long hold-off

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  sprite_bitplane_row_packer i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  sprite_row_check u_sprite_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked),
    .frames_closed (frames_closed)
  );

  // watchdog: any accepted word on either channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", idle_cycles);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: runs of ready, short or occasionally long stalls, and one
  // long hold-off on request so the job queue fills and in_ready drops
  initial begin
    int run_len;
    int gap;
    int r;
    out_ready <= 1'b0;
    forever begin
      if (stall_req) begin
        stall_req = 1'b0;
        out_ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
      end else begin
        run_len = $urandom_range(1, 40);
        out_ready <= 1'b1;
        repeat (run_len) @(posedge clk);
        r = $urandom_range(0, 99);
        if (r < 40) gap = 0;
        else if (r < 90) gap = $urandom_range(1, 3);
        else gap = $urandom_range(8, 30);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
  end

  function automatic int pixel_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_word_t random_pixel();
    in_word_t px;
    px.pixel_visible = ($urandom_range(0, 9) != 0);
    px.pixel_code    = 2'($urandom_range(0, 3));
    return px;
  endfunction

  // offer one pixel word and hold it until taken; valid stays high when
  // the next word follows without a gap
  task automatic push_pixel(logic vis, logic [1:0] code);
    int gap;
    in_word_t px;
    px.pixel_visible = vis;
    px.pixel_code    = code;
    gap = pixel_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (!in_ready);
    pixels_sent++;
  endtask

  // sender pause: wait until every predicted sprite word has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // registers change only with the block idle; a pixel that made no word may
  // still leave the back end busy, hence the settle time
  task automatic set_regs(logic [CFG_DATA_W-1:0] width_val,
                          logic [CFG_DATA_W-1:0] height_val);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SOURCE_WIDTH;
    cfg_data  <= width_val;
    @(posedge clk);
    cfg_index <= CFG_SOURCE_HEIGHT;
    cfg_data  <= height_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] w_raw;
    logic [CFG_DATA_W-1:0] h_raw;
    in_word_t px;
    int w_eff;
    int h_eff;
    int n;
    int r;

    rst_n       <= 1'b0;
    cfg_we      <= 1'b0;
    cfg_index   <= CFG_SOURCE_WIDTH;
    cfg_data    <= '0;
    in_valid    <= 1'b0;
    in_data     <= '0;
    pixels_sent   = 0;
    settings_used = 0;
    burst_mode    = 1'b0;
    stall_req     = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset setting 16x16: a few pixels open a frame and send the header
    push_pixel(1'b1, 2'd3);
    push_pixel(1'b1, 2'd1);
    push_pixel(1'b0, 2'd2);

    // one pixel frames; the first pixel also closes the open row mid frame
    // because column 3 is already past width-1
    set_regs(9'd1, 9'd1);
    push_pixel(1'b1, 2'd2);
    push_pixel(1'b1, 2'd0);
    push_pixel(1'b1, 2'd1);
    push_pixel(1'b1, 2'd3);
    push_pixel(1'b0, 2'd3);

    // zero width and zero height act as one; bit 8 of the height write is dropped
    set_regs(9'd0, 9'h100);
    push_pixel(1'b1, 2'd3);
    push_pixel(1'b1, 2'd1);

    // width above the maximum saturates to 256
    set_regs(9'd511, 9'd2);
    push_pixel(1'b1, 2'd3);
    push_pixel(1'b1, 2'd2);
    push_pixel(1'b1, 2'd1);
    push_pixel(1'b1, 2'd3);
    push_pixel(1'b0, 2'd1);

    // width shrinks under the column count: the pixel at column 5 is past
    // the row, sets nothing and ends the row at once
    set_regs(9'd3, 9'd2);
    push_pixel(1'b1, 2'd3);
    push_pixel(1'b1, 2'd1);
    push_pixel(1'b1, 2'd2);
    push_pixel(1'b1, 2'd3);

    // tallest frame, then full width, then the height drops under the
    // completed row count and the frame ends early
    set_regs(9'd1, 9'd255);
    push_pixel(1'b1, 2'd1);
    push_pixel(1'b1, 2'd2);
    push_pixel(1'b1, 2'd3);
    set_regs(9'd256, 9'd255);
    push_pixel(1'b1, 2'd3);
    set_regs(9'd1, 9'd1);
    push_pixel(1'b1, 2'd1);

    // back pressure: the receiver holds off while pixels keep coming;
    // the burst starts only once the hold-off has begun
    set_regs(9'd2, 9'd3);
    burst_mode = 1'b1;
    stall_req  = 1'b1;
    wait (!stall_req);
    repeat (40) begin
      px = random_pixel();
      push_pixel(px.pixel_visible, px.pixel_code);
    end
    burst_mode = 1'b0;

    // random settings, mostly whole frames of small sprites, some cut short
    while (pixels_sent < PIXEL_TARGET) begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        w_raw = 9'($urandom_range(1, 12));
        h_raw = 9'($urandom_range(1, 4));
      end else if (r < 80) begin
        w_raw = 9'($urandom_range(13, 40));
        h_raw = 9'($urandom_range(1, 3));
      end else if (r < 90) begin
        w_raw = 9'($urandom_range(0, 1));
        h_raw = ($urandom_range(0, 1) != 0) ? 9'd0 : 9'd255;
      end else begin
        w_raw = 9'($urandom_range(256, 511));
        h_raw = 9'($urandom_range(0, 255));
      end
      // the unused top bit of a height write toggles at random
      h_raw[8] = 1'($urandom_range(0, 1));
      set_regs(w_raw, h_raw);

      if (w_raw == 0) w_eff = 1;
      else if (w_raw > MAX_SOURCE_WIDTH) w_eff = MAX_SOURCE_WIDTH;
      else w_eff = w_raw;
      h_eff = (h_raw[7:0] == 0) ? 1 : h_raw[7:0];

      if (w_eff * h_eff <= 64 && $urandom_range(0, 4) != 0) n = w_eff * h_eff * $urandom_range(1, 3);
      else n = $urandom_range(1, 24);
      // keep the total close to the target
      if (n > PIXEL_TARGET - pixels_sent) n = PIXEL_TARGET - pixels_sent;
      burst_mode = ($urandom_range(0, 3) == 0);
      repeat (n) begin
        px = random_pixel();
        push_pixel(px.pixel_visible, px.pixel_code);
      end
      burst_mode = 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d pixel words under %0d register settings, with one long output hold-off",
             pixels_sent, settings_used + 1);
    $display("checked %0d sprite words over %0d finished frames", words_checked, frames_closed);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
